@@ hw/rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, codes and types of the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

    // default parameter values
    localparam int DEF_COORD_WIDTH     = 32;
    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STEPS    = 18;

    // configuration register indexes
    localparam logic [1:0] REG_WHEEL_BASE    = 2'd0;
    localparam logic [1:0] REG_MIN_LOOKAHEAD = 2'd1;
    localparam logic [1:0] REG_MAX_LOOKAHEAD = 2'd2;

    // register reset values
    localparam logic [15:0] WHEEL_BASE_RST    = 16'd655;
    localparam logic [15:0] MIN_LOOKAHEAD_RST = 16'd2176;
    localparam logic [15:0] MAX_LOOKAHEAD_RST = 16'd2688;

    // angles in Q30 radians
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint GAIN_Q20    = 64'sd636751;

    // look-ahead: 10 km/h in Q8.8 m/s, slow look-ahead 5 m, 9/5 by reciprocal
    localparam logic [16:0] SPEED_FAST   = 17'd712;
    localparam logic [15:0] LOOK_SLOW    = 16'd1280;
    localparam logic [23:0] MUL_NINE_FIFTHS = 24'd7549749;   // 9 * ceil(2^22 / 5)
    localparam int          NINE_FIFTHS_SHIFT = 22;
    localparam longint      FAR_BOUND = 64'sd33554432;        // 2^25

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_ctrl_t;

    // arctangent of 2^-i in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd843314857;
            5'd1:    val = 30'd497837830;
            5'd2:    val = 30'd263043837;
            5'd3:    val = 30'd133525159;
            5'd4:    val = 30'd67021688;
            5'd5:    val = 30'd33543515;
            5'd6:    val = 30'd16775852;
            5'd7:    val = 30'd8388438;
            5'd8:    val = 30'd4194283;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048576;
            5'd11:   val = 30'd524288;
            5'd12:   val = 30'd262144;
            5'd13:   val = 30'd131072;
            5'd14:   val = 30'd65536;
            5'd15:   val = 30'd32768;
            5'd16:   val = 30'd16384;
            5'd17:   val = 30'd8192;
            5'd18:   val = 30'd4096;
            5'd19:   val = 30'd2048;
            5'd20:   val = 30'd1024;
            5'd21:   val = 30'd512;
            5'd22:   val = 30'd256;
            5'd23:   val = 30'd128;
            5'd24:   val = 30'd64;
            5'd25:   val = 30'd32;
            5'd26:   val = 30'd16;
            5'd27:   val = 30'd8;
            5'd28:   val = 30'd4;
            5'd29:   val = 30'd2;
            5'd30:   val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/pps_front.sv @@
// ----------------------------------------------------------------------------
// pps_front
// Takes track point words, computes the look-ahead, runs the far test and
// keeps the preview point; on the end of a track it posts one job.
// ----------------------------------------------------------------------------
module pps_front #(
    parameter int COORD_WIDTH     = pps_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = pps_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [15:0]                          min_lookahead,
    input  logic [15:0]                          max_lookahead,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_y,
    input  logic signed [COORD_WIDTH-1:0]        vehicle_x,
    input  logic signed [COORD_WIDTH-1:0]        vehicle_y,
    input  logic signed [ANGLE_FRAC_BITS+3:0]    vehicle_heading,
    input  logic signed [15:0]                   vehicle_speed,
    input  logic                                 point_present,
    input  logic                                 last_point,
    output logic                                 job_valid,
    input  logic                                 job_ready,
    output logic                                 job_empty,
    output logic signed [COORD_WIDTH-1:0]        job_tx,
    output logic signed [COORD_WIDTH-1:0]        job_ty,
    output logic signed [COORD_WIDTH:0]          job_dx,
    output logic signed [COORD_WIDTH:0]          job_dy,
    output logic signed [ANGLE_FRAC_BITS+3:0]    job_hd
);
    import pps_pkg::*;

    localparam int CW = COORD_WIDTH;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LOOK,
        F_SQUARE,
        F_UPDATE,
        F_PUSH
    } front_state_t;

    front_state_t                      state_reg;
    logic signed [CW-1:0]              px_reg, py_reg, vx_reg, vy_reg;
    logic signed [ANGLE_FRAC_BITS+3:0] hd_reg;
    logic signed [15:0]                speed_reg;
    logic                              present_reg, last_reg;
    logic [15:0]                       look_reg;
    logic [CW:0]                       ax_reg, ay_reg;
    logic                              big_reg;
    logic [49:0]                       sx_reg, sy_reg;
    logic [47:0]                       ll_reg;
    logic                              found_reg, seen_reg;
    logic signed [CW-1:0]              held_x_reg, held_y_reg;

    logic [16:0]        asp;
    logic [40:0]        look_prod;
    logic [15:0]        look_raw, look_sel, look_next;
    logic signed [CW:0] dx, dy, tdx, tdy;
    logic [CW:0]        ax_next, ay_next;
    logic               big_next, far;
    logic [23:0]        look_q16;

    // look-ahead from speed, then clamp
    always_comb
    begin
        asp = (speed_reg < 0) ? 17'(-$signed({speed_reg[15], speed_reg}))
                              : {1'b0, speed_reg};
        look_prod = 41'(asp) * 41'(MUL_NINE_FIFTHS);
        look_raw  = 16'(look_prod >> NINE_FIFTHS_SHIFT);
        look_sel  = (asp >= SPEED_FAST) ? look_raw : LOOK_SLOW;
        if (look_sel < min_lookahead)
            look_next = min_lookahead;
        else if (look_sel > max_lookahead)
            look_next = max_lookahead;
        else
            look_next = look_sel;
    end

    // offsets of the point from the vehicle
    always_comb
    begin
        dx = (CW+1)'(px_reg) - (CW+1)'(vx_reg);
        dy = (CW+1)'(py_reg) - (CW+1)'(vy_reg);
        ax_next = (dx < 0) ? (CW+1)'(-dx) : (CW+1)'(dx);
        ay_next = (dy < 0) ? (CW+1)'(-dy) : (CW+1)'(dy);
        big_next = (64'(ax_next) >= 64'(FAR_BOUND)) || (64'(ay_next) >= 64'(FAR_BOUND));
        look_q16 = {look_reg, 8'h00};
        far = big_reg || ((51'(sx_reg) + 51'(sy_reg)) > 51'(ll_reg));
    end

    // job word toward the steer unit
    always_comb
    begin
        tdx       = (CW+1)'(held_x_reg) - (CW+1)'(vx_reg);
        tdy       = (CW+1)'(held_y_reg) - (CW+1)'(vy_reg);
        job_valid = (state_reg == F_PUSH);
        job_empty = !seen_reg;
        job_tx    = seen_reg ? held_x_reg : '0;
        job_ty    = seen_reg ? held_y_reg : '0;
        job_dx    = tdx;
        job_dy    = tdy;
        job_hd    = hd_reg;
        in_ready  = (state_reg == F_IDLE);
    end

    // sequencer and held point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            found_reg  <= 1'b0;
            seen_reg   <= 1'b0;
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg      <= point_x;
                        py_reg      <= point_y;
                        vx_reg      <= vehicle_x;
                        vy_reg      <= vehicle_y;
                        hd_reg      <= vehicle_heading;
                        speed_reg   <= vehicle_speed;
                        present_reg <= point_present;
                        last_reg    <= last_point;
                        state_reg   <= F_LOOK;
                    end
                end
                F_LOOK:
                begin
                    look_reg  <= look_next;
                    ax_reg    <= ax_next;
                    ay_reg    <= ay_next;
                    big_reg   <= big_next;
                    state_reg <= F_SQUARE;
                end
                F_SQUARE:
                begin
                    sx_reg    <= 50'(ax_reg[24:0]) * 50'(ax_reg[24:0]);
                    sy_reg    <= 50'(ay_reg[24:0]) * 50'(ay_reg[24:0]);
                    ll_reg    <= 48'(look_q16) * 48'(look_q16);
                    state_reg <= F_UPDATE;
                end
                F_UPDATE:
                begin
                    if (present_reg)
                    begin
                        seen_reg <= 1'b1;
                        if (!found_reg)
                        begin
                            held_x_reg <= px_reg;
                            held_y_reg <= py_reg;
                            if (far)
                                found_reg <= 1'b1;
                        end
                    end
                    state_reg <= last_reg ? F_PUSH : F_IDLE;
                end
                F_PUSH:
                begin
                    if (job_ready)
                    begin
                        found_reg <= 1'b0;
                        seen_reg  <= 1'b0;
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/pps_queue.sv @@
// ----------------------------------------------------------------------------
// pps_queue
// Two-entry job queue between the point front end and the steer unit.
// ----------------------------------------------------------------------------
module pps_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);
    logic [DATA_WIDTH-1:0] entry_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  do_push, do_pop;

    always_comb
    begin
        push_ready = (count_reg != 2'd2);
        pop_valid  = (count_reg != 2'd0);
        pop_data   = entry_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ hw/rtl/pps_cordic.sv @@
// ----------------------------------------------------------------------------
// pps_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module pps_cordic #(
    parameter int XW    = 60,
    parameter int ZW    = 34,
    parameter int STEPS = pps_pkg::DEF_CORDIC_STEPS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pps_pkg::cordic_ctrl_t  ctrl,
    input  logic signed [XW-1:0]   x_in,
    input  logic signed [XW-1:0]   y_in,
    input  logic signed [ZW-1:0]   z_in,
    output logic                   done,
    output logic signed [XW-1:0]   x_out,
    output logic signed [XW-1:0]   y_out,
    output logic signed [ZW-1:0]   z_out
);
    import pps_pkg::*;

    localparam int SW = $clog2(STEPS);

    cordic_mode_t          mode_reg;
    logic                  busy_reg, done_reg;
    logic [SW-1:0]         step_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;

    logic signed [XW-1:0]  xs, ys, x_nx, y_nx;
    logic signed [ZW-1:0]  at, z_nx;
    logic                  up;

    // one micro-rotation
    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = ZW'($signed({1'b0, atan_q30(5'(step_reg))}));
        up = (mode_reg == CORDIC_VECTOR) ? (y_reg > 0) : (z_reg < 0);
        if (up)
        begin
            x_nx = x_reg + ys;
            y_nx = y_reg - xs;
            z_nx = z_reg + at;
        end
        else
        begin
            x_nx = x_reg - ys;
            y_nx = y_reg + xs;
            z_nx = z_reg - at;
        end
        done  = done_reg;
        x_out = x_reg;
        y_out = y_reg;
        z_out = z_reg;
    end

    // iteration control, with a quarter turn first when vectoring from the left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            mode_reg <= CORDIC_ROTATE;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                mode_reg <= ctrl.mode;
                if (ctrl.mode == CORDIC_VECTOR)
                begin
                    if (x_in < 0)
                    begin
                        if (y_in >= 0)
                        begin
                            x_reg <= y_in;
                            y_reg <= -x_in;
                            z_reg <= ZW'(Q30_HALF_PI);
                        end
                        else
                        begin
                            x_reg <= -y_in;
                            y_reg <= x_in;
                            z_reg <= -ZW'(Q30_HALF_PI);
                        end
                    end
                    else
                    begin
                        x_reg <= x_in;
                        y_reg <= y_in;
                        z_reg <= '0;
                    end
                end
                else
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= z_in;
                end
            end
            else if (busy_reg)
            begin
                x_reg <= x_nx;
                y_reg <= y_nx;
                z_reg <= z_nx;
                if (step_reg == SW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/pps_back.sv @@
// ----------------------------------------------------------------------------
// pps_back
// Steer unit: bearing and distance, bearing error, sine and final arctangent
// on one shared CORDIC, then the result word register.
// ----------------------------------------------------------------------------
module pps_back #(
    parameter int COORD_WIDTH     = pps_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = pps_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STEPS    = pps_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [15:0]                          wheel_base,
    input  logic [15:0]                          min_lookahead,
    input  logic                                 job_valid,
    output logic                                 job_ready,
    input  logic                                 job_empty,
    input  logic signed [COORD_WIDTH-1:0]        job_tx,
    input  logic signed [COORD_WIDTH-1:0]        job_ty,
    input  logic signed [COORD_WIDTH:0]          job_dx,
    input  logic signed [COORD_WIDTH:0]          job_dy,
    input  logic signed [ANGLE_FRAC_BITS+3:0]    job_hd,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ANGLE_FRAC_BITS+1:0]    steer_angle,
    output logic signed [COORD_WIDTH-1:0]        target_x,
    output logic signed [COORD_WIDTH-1:0]        target_y,
    output logic                                 track_empty
);
    import pps_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int AFB = ANGLE_FRAC_BITS;
    localparam int XW  = (CW + 4 > 60) ? CW + 4 : 60;
    localparam int ZW  = 34;
    localparam int TW  = AFB + 4;                 // rounded angle
    localparam int EW  = 36;                      // bearing error in Q30
    localparam int NW  = 50;                      // sine numerator
    localparam int RS  = 30 - AFB;                // Q30 to output scale
    localparam longint HALF_L = (Q30_HALF_PI + (64'sd1 <<< (29 - AFB))) >>> RS;
    localparam longint CHORD_BIG = 64'sd8589934592;   // 2^33

    typedef enum logic [3:0] {
        B_IDLE,
        B_VEC1,
        B_GAIN,
        B_DIST,
        B_ERR,
        B_WRAP,
        B_SIN,
        B_NUM,
        B_VEC2,
        B_OUT
    } back_state_t;

    back_state_t              state_reg;
    logic                     empty_reg;
    logic signed [CW-1:0]     tx_reg, ty_reg;
    logic signed [AFB+3:0]    hd_reg;
    logic signed [TW-1:0]     theta_reg;
    logic [XW-1:0]            mag_reg, hi_p_reg, dist_reg;
    logic [39:0]              lo_p_reg;
    logic signed [EW-1:0]     e30_reg;
    logic signed [NW-1:0]     num_reg;
    logic signed [AFB+1:0]    steer_reg;
    logic                     out_valid_reg;
    logic signed [AFB+1:0]    steer_out_reg;
    logic signed [CW-1:0]     tx_out_reg, ty_out_reg;
    logic                     empty_out_reg;

    cordic_ctrl_t             cctrl;
    logic signed [XW-1:0]     cx_in, cy_in, cx_out, cy_out;
    logic signed [ZW-1:0]     cz_in, cz_out;
    logic                     cdone;

    logic signed [ZW-1:0]     z_rnd_full;
    logic signed [TW-1:0]     z_rnd;
    logic signed [TW:0]       err;
    logic [TW:0]              aerr;
    logic                     straight;
    logic signed [EW-1:0]     e_fold;
    logic [XW-1:0]            den, min_q16;
    logic                     den_small, out_free;
    logic signed [TW-1:0]     z_sat;

    pps_cordic #(
        .XW    (XW),
        .ZW    (ZW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cctrl),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .z_in  (cz_in),
        .done  (cdone),
        .x_out (cx_out),
        .y_out (cy_out),
        .z_out (cz_out)
    );

    // angle rounding, error, fold and chord
    always_comb
    begin
        z_rnd_full = (cz_out + ZW'(64'sd1 <<< (29 - AFB))) >>> RS;
        z_rnd      = TW'(z_rnd_full);
        err        = (TW+1)'(theta_reg) - (TW+1)'(hd_reg);
        aerr       = (err < 0) ? (TW+1)'(-err) : (TW+1)'(err);
        straight   = (64'(aerr) * 64'd1000) < (64'd1 << AFB);
        if (e30_reg > EW'(Q30_HALF_PI))
            e_fold = EW'(Q30_PI) - e30_reg;
        else if (e30_reg < -EW'(Q30_HALF_PI))
            e_fold = -EW'(Q30_PI) - e30_reg;
        else
            e_fold = e30_reg;
        min_q16   = XW'({min_lookahead, 8'h00});
        den       = (dist_reg > min_q16) ? dist_reg : min_q16;
        den_small = (64'(den) < 64'(CHORD_BIG));
        if (z_rnd > TW'(HALF_L))
            z_sat = TW'(HALF_L);
        else if (z_rnd < -TW'(HALF_L))
            z_sat = -TW'(HALF_L);
        else
            z_sat = z_rnd;
        out_free  = !out_valid_reg || out_ready;
    end

    // cordic launch per phase
    always_comb
    begin
        cctrl.start = 1'b0;
        cctrl.mode  = CORDIC_VECTOR;
        cx_in       = XW'(job_dx);
        cy_in       = XW'(job_dy);
        cz_in       = ZW'(e_fold);
        unique case (state_reg)
            B_IDLE:
            begin
                cctrl.start = job_valid && !job_empty && (job_dx != 0 || job_dy != 0);
            end
            B_WRAP:
            begin
                cctrl.mode  = CORDIC_ROTATE;
                cctrl.start = !(e30_reg > EW'(Q30_PI)) && !(e30_reg <= -EW'(Q30_PI));
                cx_in       = XW'(GAIN_Q30);
                cy_in       = '0;
            end
            B_NUM:
            begin
                cctrl.start = (num_reg != 0) && (den != 0);
                cx_in       = den_small ? XW'(den << 22) : den;
                cy_in       = den_small ? XW'(num_reg) : XW'(num_reg >>> 22);
            end
            default: cctrl.start = 1'b0;
        endcase
        job_ready   = (state_reg == B_IDLE);
        out_valid   = out_valid_reg;
        steer_angle = steer_out_reg;
        target_x    = tx_out_reg;
        target_y    = ty_out_reg;
        track_empty = empty_out_reg;
    end

    // steer sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result word valid flag
            if (state_reg == B_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        empty_reg <= job_empty;
                        tx_reg    <= job_tx;
                        ty_reg    <= job_ty;
                        hd_reg    <= job_hd;
                        if (job_empty)
                        begin
                            steer_reg <= '0;
                            state_reg <= B_OUT;
                        end
                        else if (job_dx == 0 && job_dy == 0)
                        begin
                            // vehicle sits on the point
                            theta_reg <= '0;
                            dist_reg  <= '0;
                            state_reg <= B_ERR;
                        end
                        else
                        begin
                            state_reg <= B_VEC1;
                        end
                    end
                end
                B_VEC1:
                begin
                    if (cdone)
                    begin
                        theta_reg <= z_rnd;
                        mag_reg   <= (cx_out < 0) ? '0 : XW'(cx_out);
                        state_reg <= B_GAIN;
                    end
                end
                B_GAIN:
                begin
                    hi_p_reg  <= XW'((mag_reg >> 20) * XW'(GAIN_Q20));
                    lo_p_reg  <= 40'(mag_reg[19:0]) * 40'(GAIN_Q20);
                    state_reg <= B_DIST;
                end
                B_DIST:
                begin
                    dist_reg  <= hi_p_reg + XW'(lo_p_reg >> 20);
                    state_reg <= B_ERR;
                end
                B_ERR:
                begin
                    if (straight)
                    begin
                        steer_reg <= '0;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        e30_reg   <= EW'(err) <<< RS;
                        state_reg <= B_WRAP;
                    end
                end
                B_WRAP:
                begin
                    // one turn of 2 pi per cycle into (-pi, pi]
                    if (e30_reg > EW'(Q30_PI))
                        e30_reg <= e30_reg - EW'(Q30_TWO_PI);
                    else if (e30_reg <= -EW'(Q30_PI))
                        e30_reg <= e30_reg + EW'(Q30_TWO_PI);
                    else
                        state_reg <= B_SIN;
                end
                B_SIN:
                begin
                    if (cdone)
                    begin
                        num_reg   <= $signed(NW'({wheel_base, 1'b0})) * NW'(cy_out);
                        state_reg <= B_NUM;
                    end
                end
                B_NUM:
                begin
                    if (num_reg == 0)
                    begin
                        steer_reg <= '0;
                        state_reg <= B_OUT;
                    end
                    else if (den == 0)
                    begin
                        steer_reg <= -(AFB+2)'(HALF_L);
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        state_reg <= B_VEC2;
                    end
                end
                B_VEC2:
                begin
                    if (cdone)
                    begin
                        steer_reg <= (AFB+2)'(z_sat);
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        steer_out_reg <= steer_reg;
                        tx_out_reg    <= empty_reg ? '0 : tx_reg;
                        ty_out_reg    <= empty_reg ? '0 : ty_reg;
                        empty_out_reg <= empty_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/pure_pursuit_steering.sv @@
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Pure pursuit steering: look-ahead point search over a track and steer
// angle from a shared iterative CORDIC.
// ----------------------------------------------------------------------------
// Each track point word passes the front end steps in order (accept,
// look-ahead, squares, compare), and the word that ends a track also posts
// its job into a two-entry queue. The steer unit takes one job at a time: up
// to three CORDIC passes on the one shared CORDIC, plus setup, error wrap and
// rounding; the CORDIC passes set the time per track.
// The front end keeps taking the points of the next track while a steer
// result is being computed or waits in the output register.
module pure_pursuit_steering #(
    parameter int COORD_WIDTH     = pps_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = pps_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STEPS    = pps_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [15:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_y,
    input  logic signed [COORD_WIDTH-1:0]        vehicle_x,
    input  logic signed [COORD_WIDTH-1:0]        vehicle_y,
    input  logic signed [ANGLE_FRAC_BITS+3:0]    vehicle_heading,
    input  logic signed [15:0]                   vehicle_speed,
    input  logic                                 point_present,
    input  logic                                 last_point,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ANGLE_FRAC_BITS+1:0]    steer_angle,
    output logic signed [COORD_WIDTH-1:0]        target_x,
    output logic signed [COORD_WIDTH-1:0]        target_y,
    output logic                                 track_empty
);
    import pps_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int HW = ANGLE_FRAC_BITS + 4;
    localparam int QW = 1 + 2 * CW + 2 * (CW + 1) + HW;

    logic [15:0] wheel_base_reg, min_look_reg, max_look_reg;

    logic                  f_valid, f_ready, f_empty;
    logic signed [CW-1:0]  f_tx, f_ty;
    logic signed [CW:0]    f_dx, f_dy;
    logic signed [HW-1:0]  f_hd;
    logic                  b_valid, b_ready;
    logic [QW-1:0]         q_in, q_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_base_reg <= WHEEL_BASE_RST;
            min_look_reg   <= MIN_LOOKAHEAD_RST;
            max_look_reg   <= MAX_LOOKAHEAD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WHEEL_BASE:    wheel_base_reg <= cfg_data;
                REG_MIN_LOOKAHEAD: min_look_reg   <= cfg_data;
                REG_MAX_LOOKAHEAD: max_look_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    pps_front #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .min_lookahead   (min_look_reg),
        .max_lookahead   (max_look_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .point_x         (point_x),
        .point_y         (point_y),
        .vehicle_x       (vehicle_x),
        .vehicle_y       (vehicle_y),
        .vehicle_heading (vehicle_heading),
        .vehicle_speed   (vehicle_speed),
        .point_present   (point_present),
        .last_point      (last_point),
        .job_valid       (f_valid),
        .job_ready       (f_ready),
        .job_empty       (f_empty),
        .job_tx          (f_tx),
        .job_ty          (f_ty),
        .job_dx          (f_dx),
        .job_dy          (f_dy),
        .job_hd          (f_hd)
    );

    // job word packing
    assign q_in = {f_empty, f_tx, f_ty, f_dx, f_dy, f_hd};

    pps_queue #(
        .DATA_WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    pps_back #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wheel_base    (wheel_base_reg),
        .min_lookahead (min_look_reg),
        .job_valid     (b_valid),
        .job_ready     (b_ready),
        .job_empty     (q_out[QW-1]),
        .job_tx        ($signed(q_out[QW-2 -: CW])),
        .job_ty        ($signed(q_out[QW-2-CW -: CW])),
        .job_dx        ($signed(q_out[HW+2*(CW+1)-1 -: CW+1])),
        .job_dy        ($signed(q_out[HW+CW -: CW+1])),
        .job_hd        ($signed(q_out[HW-1:0])),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .steer_angle   (steer_angle),
        .target_x      (target_x),
        .target_y      (target_y),
        .track_empty   (track_empty)
    );

endmodule

@@ tb/pure_pursuit_steering_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pure_pursuit_steering_test
// Self-checking bench for the pure pursuit steering block: tracks of point
// words go in under random idling and stalls, and every steer word that comes
// out is checked against a bit-exact model of the look-ahead search and the
// CORDIC steer math, across several register settings.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_test;
    import pps_pkg::*;

    localparam int STEPS      = DEF_CORDIC_STEPS;
    localparam int SETTLE     = 3 * STEPS + 60;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic signed [19:0] hd;
        logic signed [15:0] sp;
        logic               pres, last;
    } track_word_t;

    typedef struct {
        logic signed [17:0] steer;
        logic signed [31:0] tx, ty;
        logic               empty;
    } steer_word_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [1:0] cfg_index = REG_WHEEL_BASE;
    logic [15:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [31:0] point_x = 0, point_y = 0, vehicle_x = 0, vehicle_y = 0;
    logic signed [19:0] vehicle_heading = 0;
    logic signed [15:0] vehicle_speed = 0;
    logic point_present = 0, last_point = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [17:0] steer_angle;
    logic signed [31:0] target_x, target_y;
    logic track_empty;

    pure_pursuit_steering dut (.*);

    // clock and reset
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
    end

    // model state
    longint wheel_base_m = WHEEL_BASE_RST;
    longint min_look_m = MIN_LOOKAHEAD_RST;
    longint max_look_m = MAX_LOOKAHEAD_RST;
    bit     found_m = 0, seen_m = 0;
    longint held_x_m = 0, held_y_m = 0;

    track_word_t pending_words[$];
    steer_word_t steer_due[$];

    int send_idle_pct = 0, recv_idle_pct = 0;
    bit hold_go = 0;
    int mismatches = 0, words_taken = 0, steers_seen = 0, empties_seen = 0;

    longint arctan_tbl[32] = '{
        843314857, 497837830, 263043837, 133525159, 67021688,
        33543515, 16775852, 8388438, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128,
        64, 32, 16, 8, 4, 2, 1, 0};

    function automatic longint round_q30(longint z);
        return (z + (64'sd1 << 13)) >>> 14;
    endfunction

    // vectoring pass: returns angle in Q30, magnitude through mag
    function automatic longint cordic_angle(longint x, longint y, output longint mag);
        longint z, t, xs, ys;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = Q30_HALF_PI;
            end
            else
            begin
                t = x; x = -y; y = t; z = -Q30_HALF_PI;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += arctan_tbl[i];
            end
            else
            begin
                x -= ys; y += xs; z -= arctan_tbl[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint cordic_sine(longint a);
        longint x, y, z, xs, ys;
        x = GAIN_Q30; y = 0; z = a;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= arctan_tbl[i];
            end
            else
            begin
                x += ys; y -= xs; z += arctan_tbl[i];
            end
        end
        return y;
    endfunction

    function automatic longint steer_angle_for(longint dx, longint dy, longint hd);
        longint theta, chord, mag, err, aerr, e30, num, den, z, half;
        half = round_q30(Q30_HALF_PI);
        theta = 0;
        chord = 0;
        if (dx != 0 || dy != 0)
        begin
            theta = round_q30(cordic_angle(dx, dy, mag));
            if (mag < 0)
                mag = 0;
            chord = (mag >>> 20) * GAIN_Q20 + (((mag & 64'hFFFFF) * GAIN_Q20) >>> 20);
        end
        err = theta - hd;
        aerr = err < 0 ? -err : err;
        // nearly straight ahead
        if (aerr * 1000 < 65536)
            return 0;
        e30 = err * 16384;
        while (e30 > Q30_PI) e30 -= Q30_TWO_PI;
        while (e30 <= -Q30_PI) e30 += Q30_TWO_PI;
        if (e30 > Q30_HALF_PI) e30 = Q30_PI - e30;
        else if (e30 < -Q30_HALF_PI) e30 = -Q30_PI - e30;
        num = 2 * wheel_base_m * cordic_sine(e30);
        den = min_look_m << 8;
        if (chord > den)
            den = chord;
        if (num == 0)
            return 0;
        if (den == 0)
            return -half;
        if (den < (64'sd1 << 33))
            den = den << 22;
        else
            num = num >>> 22;
        z = round_q30(cordic_angle(den, num, mag));
        if (z > half) z = half;
        if (z < -half) z = -half;
        return z;
    endfunction

    // look-ahead search, and the steer word on the end of a track
    function automatic void predict_steer(track_word_t w);
        longint asp, look, dx, dy, ax, ay, l;
        steer_word_t r;
        asp = w.sp < 0 ? -longint'(w.sp) : longint'(w.sp);
        look = (asp >= 712) ? asp * 9 / 5 : 1280;
        if (look < min_look_m) look = min_look_m;
        else if (look > max_look_m) look = max_look_m;
        if (w.pres)
        begin
            seen_m = 1;
            if (!found_m)
            begin
                held_x_m = w.px;
                held_y_m = w.py;
                dx = held_x_m - longint'(w.vx);
                dy = held_y_m - longint'(w.vy);
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                l = look << 8;
                if (ax >= FAR_BOUND || ay >= FAR_BOUND || ax * ax + ay * ay > l * l)
                    found_m = 1;
            end
        end
        if (!w.last)
            return;
        if (seen_m)
        begin
            r.steer = 18'(steer_angle_for(held_x_m - longint'(w.vx),
                                          held_y_m - longint'(w.vy), longint'(w.hd)));
            r.tx = 32'(held_x_m);
            r.ty = 32'(held_y_m);
            r.empty = 0;
        end
        else
        begin
            r.steer = 0;
            r.tx = 0;
            r.ty = 0;
            r.empty = 1;
        end
        steer_due.push_back(r);
        found_m = 0;
        seen_m = 0;
    endfunction

    // driver
    always @(posedge clk)
    begin
        track_word_t w;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                w.px = point_x; w.py = point_y; w.vx = vehicle_x; w.vy = vehicle_y;
                w.hd = vehicle_heading; w.sp = vehicle_speed;
                w.pres = point_present; w.last = last_point;
                predict_steer(w);
                words_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    point_x <= w.px; point_y <= w.py;
                    vehicle_x <= w.vx; vehicle_y <= w.vy;
                    vehicle_heading <= w.hd; vehicle_speed <= w.sp;
                    point_present <= w.pres; last_point <= w.last;
                    in_valid <= 1;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor and checker
    int hold_left = 0;
    bit hold_taken = 0;
    always @(posedge clk)
    begin
        steer_word_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                steers_seen++;
                if (track_empty) empties_seen++;
                if (steer_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected steer word: steer %0d target %0d,%0d",
                                 steer_angle, target_x, target_y);
                end
                else
                begin
                    e = steer_due.pop_front();
                    if (steer_angle !== e.steer || target_x !== e.tx ||
                        target_y !== e.ty || track_empty !== e.empty)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("steer word %0d: expected %0d %0d %0d %b, got %0d %0d %0d %b",
                                     steers_seen, e.steer, e.tx, e.ty, e.empty,
                                     steer_angle, target_x, target_y, track_empty);
                    end
                end
            end
            // long receiver hold-off so the block backs up into its input
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no word moving
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus helpers
    task automatic add_word(longint px, longint py, longint vx, longint vy,
                            longint hd, longint sp, bit pres, bit last);
        track_word_t w;
        w.px = 32'(px); w.py = 32'(py); w.vx = 32'(vx); w.vy = 32'(vy);
        w.hd = 20'(hd); w.sp = 16'(sp); w.pres = pres; w.last = last;
        pending_words.push_back(w);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_WHEEL_BASE:    wheel_base_m = val;
            REG_MIN_LOOKAHEAD: min_look_m = val;
            REG_MAX_LOOKAHEAD: max_look_m = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 0;
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || in_valid || steer_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic longint near_off();
        return longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
    endfunction

    // one random track: mostly points around the vehicle, some wild fields
    task automatic add_track();
        longint vx, vy, hd, sp, px, py;
        int n;
        bit wild;
        wild = ($urandom_range(0, 9) == 0);
        vx = wild ? longint'($signed($urandom())) : longint'($urandom_range(0, 4000000)) - 2000000;
        vy = wild ? longint'($signed($urandom())) : longint'($urandom_range(0, 4000000)) - 2000000;
        hd = wild ? longint'($urandom_range(0, 1048575)) - 524288
                  : longint'($urandom_range(0, 411774)) - 205887;
        sp = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 65535)) - 32768
                                         : longint'($urandom_range(0, 3000)) - 1500;
        // empty track now and then
        if ($urandom_range(0, 19) == 0)
        begin
            add_word(0, 0, vx, vy, hd, sp, 0, 1);
            return;
        end
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            if (wild)
            begin
                px = $signed($urandom());
                py = $signed($urandom());
            end
            else
            begin
                px = vx + near_off();
                py = vy + near_off();
            end
            // ignored empty marker, some noise
            if ($urandom_range(0, 9) == 0)
                add_word($urandom(), $urandom(), vx, vy, hd, sp, 0, 0);
            add_word(px, py, vx, vy, hd, sp,
                     (i == n - 1) ? ($urandom_range(0, 7) != 0) : 1'b1, i == n - 1);
        end
    endtask

    task automatic directed_words();
        longint m20;
        m20 = 20 * 65536;
        // vehicle right on the point, speed extremes and the fast threshold
        add_word(1000, 2000, 1000, 2000, 0, 0, 1, 1);
        add_word(1000, 2000, 1000, 2000, 100000, -32768, 1, 1);
        add_word(m20, 0, 0, 0, 0, 711, 1, 1);
        add_word(0, m20, 0, 0, 0, 712, 1, 1);
        add_word(-m20, 5, 0, 0, 524287, 32767, 1, 1);
        add_word(3, -m20, 0, 0, -524288, -712, 1, 1);
        // coordinate extremes
        add_word(32'h7FFFFFFF, 32'h7FFFFFFF, -32'sh80000000, -32'sh80000000, 0, 0, 1, 1);
        add_word(-32'sh80000000, -32'sh80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 205887, 1000, 1, 1);
        add_word(-32'sh80000000, 32'h7FFFFFFF, 0, 0, -205887, 0, 1, 1);
        // straight ahead and just off it
        add_word(m20, 0, 0, 0, 65, 0, 1, 1);
        add_word(m20, 0, 0, 0, 66, 0, 1, 1);
        // empty track, ignored marker, then a track whose second point is far
        add_word(0, 0, 0, 0, 0, 0, 0, 1);
        add_word(77, 88, 0, 0, 0, 0, 0, 0);
        add_word(65536, 65536, 0, 0, 0, 0, 1, 0);
        add_word(m20, m20, 0, 0, 0, 0, 1, 0);
        add_word(65536, 0, 0, 0, 0, 0, 1, 0);
        add_word(0, 0, 0, 0, 10000, 0, 0, 1);
        // no far point: last point is held
        add_word(65536, 0, 0, 0, 0, 0, 1, 0);
        add_word(0, 2 * 65536, 0, 0, 0, 0, 1, 1);
    endtask

    int phase_count = 0;
    initial
    begin
        @(posedge rst_n);
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: ;
                1:
                begin
                    set_reg(REG_WHEEL_BASE, 16'hFFFF);
                    set_reg(REG_MIN_LOOKAHEAD, 16'h0000);
                    set_reg(REG_MAX_LOOKAHEAD, 16'hFFFF);
                end
                2:
                begin
                    set_reg(REG_WHEEL_BASE, 16'h0000);
                    set_reg(REG_MIN_LOOKAHEAD, 16'hFFFF);
                    set_reg(REG_MAX_LOOKAHEAD, 16'h0000);
                end
                3:
                begin
                    set_reg(REG_WHEEL_BASE, 16'd700);
                    set_reg(REG_MIN_LOOKAHEAD, 16'd3000);
                    set_reg(REG_MAX_LOOKAHEAD, 16'd1000);
                end
                default:
                begin
                    set_reg(REG_WHEEL_BASE, 16'($urandom()));
                    set_reg(REG_MIN_LOOKAHEAD, 16'($urandom_range(0, 4000)));
                    set_reg(REG_MAX_LOOKAHEAD, 16'($urandom_range(0, 8000)));
                end
            endcase
            send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 51 : 0;
            recv_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 18 : 0;
            if (ph == 0 || ph == 1)
                directed_words();
            if (ph == 1)
                hold_go = 1;
            while (pending_words.size() < 250)
                add_track();
            drain();
            phase_count++;
        end
        $display("covered %0d register settings, %0d track words taken, %0d steer words (%0d empty)",
                 phase_count, words_taken, steers_seen, empties_seen);
        $display("idling on each side, a %0d-cycle receiver hold-off, %0d mismatches",
                 HOLD_LEN, mismatches);
        if (mismatches == 0 && steer_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pps_pkg.sv
hw/rtl/pps_front.sv
hw/rtl/pps_queue.sv
hw/rtl/pps_cordic.sv
hw/rtl/pps_back.sv
hw/rtl/pure_pursuit_steering.sv
tb/pure_pursuit_steering_test.sv
